@@ design/tbpd_pkg.sv @@
// Shared types and constants for the tagged byte-pair deframer.
package tbpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int WORD_IDX_W = 4;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int LANE_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_CODE  = 2'd2;

  // Reset values of the command codes
  localparam logic [BYTE_W-1:0] CONTENT_CODE_RST = 8'd1;
  localparam logic [BYTE_W-1:0] HEADER_CODE_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] FOOTER_CODE_RST  = 8'd3;

  localparam logic [LANE_W-1:0] LAST_LANE = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CONTENT = 2'd1,
    CMD_HEADER  = 2'd2,
    CMD_FOOTER  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

endpackage

@@ design/tagged_byte_pair_deframer_unit.sv @@
// Top level of the tagged byte-pair deframer: command decode, byte store, record dump.
//
// Input channel (in_valid/in_ready, data_byte) carries one received byte per
// transaction; the stream alternates a command byte and a data byte.
// Output channel (out_valid/out_ready) carries one 32-bit record word per
// transaction with its word_index, frame_length and last_word flag.
// cfg_write/cfg_index/cfg_data set the content, header and footer codes.
//
// Command and content/header bytes are accepted one byte per cycle while no
// record dump runs.
// A footer data byte starts a dump that reads the byte store through its
// single read port, one byte per cycle unless held for a busy output register
// (see below); each word passes the RAM read register, then the output register.
// Input is held off while the dump reads the store.
// The last word is registered; input is taken again while it waits.
// When the receiver stalls, the dump holds before the byte that completes
// the next word until the output register is free.
// Reset restores the default codes, returns to command phase and clears
// the per-entry written flags, so the store reads as zeros at once; no
// clearing pass is needed.
module tagged_byte_pair_deframer_unit #(
  parameter int STORE_DEPTH  = 64,
  parameter int RECORD_WORDS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tbpd_pkg::BYTE_W-1:0]        data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tbpd_pkg::WORD_W-1:0]        record_word,
  output logic [tbpd_pkg::WORD_IDX_W-1:0]    word_index,
  output logic [tbpd_pkg::LEN_W-1:0]         frame_length,
  output logic                               last_word,
  input  logic                               cfg_write,
  input  logic [tbpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbpd_pkg::BYTE_W-1:0]        cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IDX_W = tbpd_pkg::WORD_IDX_W + tbpd_pkg::LANE_W;
  localparam int CMP_W = (AW > IDX_W) ? AW + 1 : IDX_W + 1;

  tbpd_pkg::state_t state, state_next;
  tbpd_pkg::cmd_t   active_cmd, active_cmd_next;
  logic             expect_command, expect_command_next;
  logic [AW-1:0]    fill_index, fill_index_next;
  logic [tbpd_pkg::LEN_W-1:0] dump_len, dump_len_next;
  logic [tbpd_pkg::WORD_IDX_W-1:0] word_cnt, word_cnt_next;
  logic [tbpd_pkg::LANE_W-1:0] lane, lane_next;

  logic [tbpd_pkg::BYTE_W-1:0] content_code, header_code, footer_code;
  logic [STORE_DEPTH-1:0]      written;

  logic                        ram_we;
  logic                        rd_en;
  logic [AW-1:0]               ram_raddr;
  logic [tbpd_pkg::BYTE_W-1:0] ram_rdata;
  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_beyond;

  logic                        rd_issue;
  logic [tbpd_pkg::LANE_W-1:0] rd_lane;
  logic [tbpd_pkg::WORD_IDX_W-1:0] rd_word;
  logic                        rd_zero;
  logic [tbpd_pkg::BYTE_W-1:0] rd_byte;
  logic [23:0]                 word_acc;
  logic                        word_load;

  tbpd_ram #(
    .WIDTH(tbpd_pkg::BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_index),
    .wdata(data_byte),
    .re   (rd_en),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_idx    = {word_cnt, lane};
  assign rd_beyond = CMP_W'(rd_idx) >= CMP_W'(STORE_DEPTH);
  assign ram_raddr = AW'(rd_idx);
  assign in_ready  = (state == tbpd_pkg::ST_RUN);

  always_comb begin
    state_next          = state;
    active_cmd_next     = active_cmd;
    expect_command_next = expect_command;
    fill_index_next     = fill_index;
    dump_len_next       = dump_len;
    word_cnt_next       = word_cnt;
    lane_next           = lane;
    ram_we              = 1'b0;
    rd_en               = 1'b0;
    case (state)
      tbpd_pkg::ST_RUN: begin
        if (in_valid) begin
          if (expect_command) begin
            if (data_byte == content_code) begin
              active_cmd_next     = tbpd_pkg::CMD_CONTENT;
              expect_command_next = 1'b0;
            end else if (data_byte == header_code) begin
              active_cmd_next     = tbpd_pkg::CMD_HEADER;
              expect_command_next = 1'b0;
            end else if (data_byte == footer_code) begin
              active_cmd_next     = tbpd_pkg::CMD_FOOTER;
              expect_command_next = 1'b0;
            end
          end else begin
            expect_command_next = 1'b1;
            case (active_cmd)
              tbpd_pkg::CMD_CONTENT: begin
                ram_we = 1'b1;
                if (fill_index == AW'(STORE_DEPTH - 1)) begin
                  fill_index_next = '0;
                end else begin
                  fill_index_next = fill_index + AW'(1);
                end
              end
              tbpd_pkg::CMD_HEADER: begin
                fill_index_next = '0;
              end
              tbpd_pkg::CMD_FOOTER: begin
                dump_len_next   = fill_index[tbpd_pkg::LEN_W-1:0];
                fill_index_next = '0;
                word_cnt_next   = '0;
                lane_next       = '0;
                state_next      = tbpd_pkg::ST_DUMP;
              end
              default: begin
              end
            endcase
          end
        end
      end
      tbpd_pkg::ST_DUMP: begin
        // hold the word-completing read until the output register is free
        if (lane != tbpd_pkg::LAST_LANE || !out_valid) begin
          rd_en     = 1'b1;
          lane_next = lane + tbpd_pkg::LANE_W'(1);
          if (lane == tbpd_pkg::LAST_LANE) begin
            word_cnt_next = word_cnt + tbpd_pkg::WORD_IDX_W'(1);
            if (word_cnt == tbpd_pkg::WORD_IDX_W'(RECORD_WORDS - 1)) begin
              state_next = tbpd_pkg::ST_RUN;
            end
          end
        end
      end
      default: begin
        state_next = tbpd_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tbpd_pkg::ST_RUN;
      active_cmd     <= tbpd_pkg::CMD_NONE;
      expect_command <= 1'b1;
      fill_index     <= '0;
      word_cnt       <= '0;
      lane           <= '0;
    end else begin
      state          <= state_next;
      active_cmd     <= active_cmd_next;
      expect_command <= expect_command_next;
      fill_index     <= fill_index_next;
      word_cnt       <= word_cnt_next;
      lane           <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_len <= dump_len_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      content_code <= tbpd_pkg::CONTENT_CODE_RST;
      header_code  <= tbpd_pkg::HEADER_CODE_RST;
      footer_code  <= tbpd_pkg::FOOTER_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tbpd_pkg::CFG_CONTENT_CODE: content_code <= cfg_data;
        tbpd_pkg::CFG_HEADER_CODE:  header_code  <= cfg_data;
        tbpd_pkg::CFG_FOOTER_CODE:  footer_code  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[fill_index] <= 1'b1;
    end
  end

  // Track the read in flight alongside the RAM latency
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_issue <= 1'b0;
    end else begin
      rd_issue <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_lane <= lane;
    rd_word <= word_cnt;
    rd_zero <= rd_beyond || !written[ram_raddr];
  end

  assign rd_byte   = rd_zero ? '0 : ram_rdata;
  assign word_load = rd_issue && (rd_lane == tbpd_pkg::LAST_LANE);

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      case (rd_lane)
        2'd0: word_acc[7:0]   <= rd_byte;
        2'd1: word_acc[15:8]  <= rd_byte;
        2'd2: word_acc[23:16] <= rd_byte;
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_load) begin
      record_word  <= {rd_byte, word_acc};
      word_index   <= rd_word;
      frame_length <= dump_len;
      last_word    <= (rd_word == tbpd_pkg::WORD_IDX_W'(RECORD_WORDS - 1));
    end
  end

endmodule

@@ design/tbpd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/tagged_byte_pair_deframer_unit_tb.sv @@
// Self-checking testbench for the tagged byte-pair deframer unit.
`timescale 1ns / 1ps

module tagged_byte_pair_deframer_unit_tb;

  localparam int DEPTH = 64;
  localparam int WORDS = 14;
  localparam int DUMP_CYCLES = 4 * WORDS + 8;
  localparam logic [tbpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [tbpd_pkg::WORD_W-1:0]     word;
    logic [tbpd_pkg::WORD_IDX_W-1:0] idx;
    logic [tbpd_pkg::LEN_W-1:0]      len;
    logic                            last;
  } rec_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [tbpd_pkg::BYTE_W-1:0]     data_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [tbpd_pkg::WORD_W-1:0]     record_word;
  logic [tbpd_pkg::WORD_IDX_W-1:0] word_index;
  logic [tbpd_pkg::LEN_W-1:0]      frame_length;
  logic                            last_word;
  logic                            cfg_write = 1'b0;
  logic [tbpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tbpd_pkg::BYTE_W-1:0]     cfg_data = '0;

  // Deframer state mirrored by the predictor
  logic [tbpd_pkg::BYTE_W-1:0] code_content = tbpd_pkg::CONTENT_CODE_RST;
  logic [tbpd_pkg::BYTE_W-1:0] code_header  = tbpd_pkg::HEADER_CODE_RST;
  logic [tbpd_pkg::BYTE_W-1:0] code_footer  = tbpd_pkg::FOOTER_CODE_RST;
  bit                          awaiting_cmd = 1'b1;
  tbpd_pkg::cmd_t              cur_cmd = tbpd_pkg::CMD_NONE;
  int                          fill = 0;
  logic [tbpd_pkg::BYTE_W-1:0] byte_store [DEPTH];

  logic [tbpd_pkg::BYTE_W-1:0] tx_bytes [$];
  rec_word_t                   pending_words [$];
  int                          bytes_queued = 0;
  int                          bytes_taken = 0;
  int                          mismatches = 0;
  int                          items = 0;
  bit                          no_idle = 1'b0;
  bit                          hold_off_go = 1'b0;
  logic                        rx_hold = 1'b0;

  tagged_byte_pair_deframer_unit #(
    .STORE_DEPTH (DEPTH),
    .RECORD_WORDS(WORDS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .record_word (record_word),
    .word_index  (word_index),
    .frame_length(frame_length),
    .last_word   (last_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) byte_store[i] = '0;
  end

  // Advance the mirrored state by one received byte; queue any record words.
  function automatic void deframe_byte(input logic [tbpd_pkg::BYTE_W-1:0] b);
    rec_word_t w;
    int        base;
    if (awaiting_cmd) begin
      // content wins over header, header over footer
      if (b == code_content) cur_cmd = tbpd_pkg::CMD_CONTENT;
      else if (b == code_header) cur_cmd = tbpd_pkg::CMD_HEADER;
      else if (b == code_footer) cur_cmd = tbpd_pkg::CMD_FOOTER;
      else return;
      awaiting_cmd = 1'b0;
      return;
    end
    case (cur_cmd)
      tbpd_pkg::CMD_CONTENT: begin
        byte_store[fill] = b;
        fill = (fill == DEPTH - 1) ? 0 : fill + 1;
      end
      tbpd_pkg::CMD_HEADER: fill = 0;
      tbpd_pkg::CMD_FOOTER: begin
        for (int k = 0; k < WORDS; k++) begin
          base = 4 * k;
          for (int j = 0; j < 4; j++)
            w.word[8*j +: 8] = (base + j < DEPTH) ? byte_store[base + j] : 8'h00;
          w.idx  = k[tbpd_pkg::WORD_IDX_W-1:0];
          w.len  = fill[tbpd_pkg::LEN_W-1:0];
          w.last = (k == WORDS - 1);
          pending_words.push_back(w);
        end
        fill = 0;
      end
      default: ;
    endcase
    awaiting_cmd = 1'b1;
  endfunction

  function automatic void flag_mismatch(input string what, input rec_word_t exp_w,
                                        input rec_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
               $realtime, what, exp_w.word, exp_w.idx, exp_w.len, exp_w.last,
               got_w.word, got_w.idx, got_w.len, got_w.last);
  endfunction

  // Sender: offer queued bytes, hold each until its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(data_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
          in_valid  <= 1'b1;
          data_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each record word with the oldest prediction.
  always @(posedge clk) begin
    rec_word_t got_w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_w = '{record_word, word_index, frame_length, last_word};
        if (pending_words.size() == 0)
          flag_mismatch("unexpected word", '0, got_w);
        else if (pending_words[0] !== got_w)
          flag_mismatch("mismatch", pending_words.pop_front(), got_w);
        else
          void'(pending_words.pop_front());
      end
      out_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 34);
    end
  end

  // Long receiver hold-off so the dump backs up and stalls the input.
  initial begin
    wait (hold_off_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_code(input logic [tbpd_pkg::CFG_IDX_W-1:0] idx,
                            input logic [tbpd_pkg::BYTE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      tbpd_pkg::CFG_CONTENT_CODE: code_content = val;
      tbpd_pkg::CFG_HEADER_CODE:  code_header  = val;
      tbpd_pkg::CFG_FOOTER_CODE:  code_footer  = val;
      default: ;
    endcase
  endtask

  function automatic logic [tbpd_pkg::BYTE_W-1:0] rand_byte();
    return tbpd_pkg::BYTE_W'($urandom_range(255));
  endfunction

  task automatic push_byte(input logic [tbpd_pkg::BYTE_W-1:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
    items++;
  endtask

  task automatic push_pair(input logic [tbpd_pkg::BYTE_W-1:0] cmd,
                           input logic [tbpd_pkg::BYTE_W-1:0] b);
    push_byte(cmd);
    push_byte(b);
  endtask

  task automatic push_frame(input int len);
    push_pair(code_header, rand_byte());
    repeat (len) push_pair(code_content, rand_byte());
    push_pair(code_footer, rand_byte());
  endtask

  // Mostly well-formed frames; the rest stray bytes and broken frames.
  task automatic push_random(input int target);
    int stop_at;
    int r;
    stop_at = items + target;
    while (items < stop_at) begin
      r = $urandom_range(99);
      if (r < 72) push_frame($urandom_range(12));
      else if (r < 82) push_byte(rand_byte());
      else if (r < 90) push_pair(code_footer, rand_byte());
      else repeat ($urandom_range(1, 3)) push_pair(code_content, rand_byte());
    end
  endtask

  // Wait until every byte is taken and every word has come, then let the block settle.
  task automatic drain();
    while (bytes_taken != bytes_queued || pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [tbpd_pkg::BYTE_W-1:0] c;
    logic [tbpd_pkg::BYTE_W-1:0] h;
    logic [tbpd_pkg::BYTE_W-1:0] f;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, empty-store record, extremes, stale bytes
    push_byte(8'hFF);
    push_byte(8'h00);
    push_pair(code_footer, 8'h00);
    push_pair(code_header, 8'hFF);
    push_pair(code_content, 8'h00);
    push_pair(code_content, 8'hFF);
    push_pair(code_content, 8'hA5);
    push_pair(code_content, 8'h5A);
    push_pair(code_content, 8'h80);
    push_pair(code_footer, 8'h7F);
    push_pair(code_content, 8'h01);
    push_pair(code_footer, 8'hFF);
    drain();

    // Extreme codes, no idling on either side
    write_code(tbpd_pkg::CFG_CONTENT_CODE, 8'h00);
    write_code(tbpd_pkg::CFG_HEADER_CODE, 8'hFF);
    write_code(tbpd_pkg::CFG_FOOTER_CODE, 8'h80);
    no_idle = 1'b1;
    push_random(60);
    drain();
    no_idle = 1'b0;

    // Random distinct codes under receiver hold-off; one frame wraps the store
    c = rand_byte();
    do h = rand_byte(); while (h == c);
    do f = rand_byte(); while (f == c || f == h);
    write_code(tbpd_pkg::CFG_CONTENT_CODE, c);
    write_code(tbpd_pkg::CFG_HEADER_CODE, h);
    write_code(tbpd_pkg::CFG_FOOTER_CODE, f);
    hold_off_go = 1'b1;
    push_frame(10);
    push_frame(66);
    push_random(45);
    drain();

    // All codes equal: every command resolves to content
    write_code(tbpd_pkg::CFG_CONTENT_CODE, 8'h5C);
    write_code(tbpd_pkg::CFG_HEADER_CODE, 8'h5C);
    write_code(tbpd_pkg::CFG_FOOTER_CODE, 8'h5C);
    repeat (4) push_pair(8'h5C, rand_byte());
    drain();

    // Header and footer equal: header wins; unused index is ignored
    write_code(tbpd_pkg::CFG_CONTENT_CODE, 8'h11);
    write_code(tbpd_pkg::CFG_HEADER_CODE, 8'h22);
    write_code(tbpd_pkg::CFG_FOOTER_CODE, 8'h22);
    write_code(CFG_UNUSED, 8'h11);
    push_pair(8'h22, 8'h33);
    push_pair(8'h11, 8'hC3);
    push_pair(8'h11, 8'h3C);
    push_pair(8'h22, 8'h00);
    drain();

    write_code(tbpd_pkg::CFG_FOOTER_CODE, 8'h7F);
    write_code(tbpd_pkg::CFG_HEADER_CODE, 8'h01);
    write_code(tbpd_pkg::CFG_CONTENT_CODE, 8'hFE);
    push_pair(code_content, 8'h99);
    push_pair(code_footer, 8'h00);
    push_random(40);
    drain();

    repeat (DUMP_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ tagged_byte_pair_deframer_unit.f @@
design/tbpd_pkg.sv
design/tbpd_ram.sv
design/tagged_byte_pair_deframer_unit.sv
tb/sv/tagged_byte_pair_deframer_unit_tb.sv
